// File: hdl/lnca_pkg.sv
// Shared types and constants for the L1 nearest-center assignment block.
// Used by every module of the block; depends on nothing.
package lnca_pkg;

   // Fixed field widths
   localparam int CIDX_W = 4;
   localparam int DIDX_W = 6;
   localparam int VAL_W  = 8;
   localparam int POS_W  = 7;
   localparam int DIST_W = 14;
   localparam int CNT_W  = 16;
   localparam int DIMS_W = 7;
   localparam int CENT_W = 5;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   // Saturation limits
   localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;
   localparam logic [CNT_W-1:0]  CNT_MAX  = 16'hFFFF;

   // Register indexes of the configuration port
   localparam logic [0:0] CSR_DIMS    = 1'b0;
   localparam logic [0:0] CSR_CENTERS = 1'b1;

   // Reset values of the configuration registers
   localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;
   localparam logic [CENT_W-1:0] CENT_RESET = 5'd16;

   // Result kinds
   localparam logic KIND_ASSIGN   = 1'b0;
   localparam logic KIND_READBACK = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } lnca_op_type;

   // Classified item as queued by the front
   typedef struct packed {
      lnca_op_type        op;
      logic               in_range;  // load or readback target exists
      logic               last;      // last coordinate of a point
      logic [CIDX_W-1:0]  cidx;
      logic [POS_W-1:0]   row;       // table row: coordinate position or load dim
      logic [VAL_W-1:0]   value;
   } lnca_item_type;

   // Result beat payload
   typedef struct packed {
      logic               kind;
      logic [CIDX_W-1:0]  center;
      logic [DIST_W-1:0]  distance;
      logic [CNT_W-1:0]   count;
   } lnca_result_type;

endpackage

// File: hdl/lnca_front.sv
// Front end: accepts request beats, tracks the coordinate position of the
// current point and classifies each beat for the back end. Uses lnca_pkg.
module lnca_front #(
   parameter int MAX_DIMS    = 64,
   parameter int MAX_CENTERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lnca_pkg::lnca_op_type         in_op,
   input  logic [lnca_pkg::CIDX_W-1:0]   in_cidx,
   input  logic [lnca_pkg::DIDX_W-1:0]   in_didx,
   input  logic [lnca_pkg::VAL_W-1:0]    in_value,
   input  logic [lnca_pkg::DIMS_W-1:0]   dims_eff,
   input  logic                          q_full,
   output logic                          q_push,
   output lnca_pkg::lnca_item_type       q_item
);

   logic [lnca_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       last;
   logic                       accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign q_push   = accept;

   // End the point once position + 1 reaches the dimension count
   assign last = ({1'b0, pos_ff} + 8'd1) >= {1'b0, dims_eff};

   // Advance or wrap the coordinate position on point beats
   always_comb begin
      pos_in = pos_ff;
      if (accept && in_op == lnca_pkg::OP_POINT) begin
         pos_in = last ? '0 : pos_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Classify the beat
   always_comb begin
      q_item.op    = in_op;
      q_item.last  = last;
      q_item.cidx  = in_cidx;
      q_item.value = in_value;
      q_item.row   = (in_op == lnca_pkg::OP_POINT) ? pos_ff : lnca_pkg::POS_W'(in_didx);
      case (in_op)
         lnca_pkg::OP_LOAD: begin
            q_item.in_range = (32'(in_cidx) < MAX_CENTERS) && (32'(in_didx) < MAX_DIMS);
         end
         lnca_pkg::OP_READ: begin
            q_item.in_range = 32'(in_cidx) < MAX_CENTERS;
         end
         default: begin
            q_item.in_range = 1'b1;
         end
      endcase
   end

endmodule

// File: hdl/lnca_fifo.sv
// Short queue of classified items between the front and the back end.
// Uses lnca_pkg for the item type and depth.
module lnca_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lnca_pkg::lnca_item_type  push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output lnca_pkg::lnca_item_type  head
);

   lnca_pkg::lnca_item_type      q_ff [lnca_pkg::QDEPTH];
   logic [lnca_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [lnca_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [lnca_pkg::QPTR_W:0]    cnt_ff, cnt_in;

   assign full  = cnt_ff == (lnca_pkg::QPTR_W+1)'(lnca_pkg::QDEPTH);
   assign empty = cnt_ff == '0;
   assign head  = q_ff[rd_ptr_ff];

   // Move pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/lnca_back.sv
// Back end: center table memory, per-center distance accumulators, nearest
// center scan, member counts and the result register. Uses lnca_pkg.
module lnca_back #(
   parameter int MAX_DIMS    = 64,
   parameter int MAX_CENTERS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lnca_pkg::lnca_item_type       head,
   input  logic                          empty,
   output logic                          pop,
   input  logic [lnca_pkg::CENT_W-1:0]   ncent_eff,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lnca_pkg::lnca_result_type     rsp_res
);

   localparam int RW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CW      = $clog2(MAX_CENTERS);
   localparam int LANES_W = MAX_CENTERS * lnca_pkg::VAL_W;

   typedef enum logic [3:0] {
      S_RUN  = 4'b0001,
      S_ACC  = 4'b0010,
      S_SCAN = 4'b0100,
      S_EMIT = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [LANES_W-1:0]           tbl_mem [MAX_DIMS];
   logic [LANES_W-1:0]           rd_data_ff;
   logic [RW-1:0]                row_addr;
   logic [CW-1:0]                lane;
   logic                         tbl_wr, tbl_rd;

   logic                         acc_vld_ff, acc_vld_in;
   logic [lnca_pkg::VAL_W-1:0]   acc_value_ff;
   logic [lnca_pkg::DIST_W-1:0]  dist_ff [MAX_CENTERS];
   logic [lnca_pkg::DIST_W-1:0]  dist_in [MAX_CENTERS];

   logic [lnca_pkg::CENT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [lnca_pkg::CENT_W-1:0]  best_ff, best_in;
   logic [lnca_pkg::DIST_W-1:0]  best_d_ff, best_d_in;
   logic [lnca_pkg::DIST_W-1:0]  dist_sel;

   logic [lnca_pkg::CNT_W-1:0]   cnt_ff [MAX_CENTERS];
   logic [CW-1:0]                cnt_idx;
   logic [lnca_pkg::CNT_W-1:0]   cnt_rd, cnt_new;

   logic                         out_free, read_fire, clear_fire, emit_fire;
   logic                         rsp_valid_ff, rsp_valid_in;
   lnca_pkg::lnca_result_type    rsp_res_ff;

   // Dispatch control
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == S_RUN) && !empty &&
                       ((head.op != lnca_pkg::OP_READ) || out_free);
   assign read_fire  = pop && (head.op == lnca_pkg::OP_READ);
   assign clear_fire = pop && (head.op == lnca_pkg::OP_CLEAR);
   assign emit_fire  = (state_ff == S_EMIT) && out_free;

   // Center table: one row per coordinate, one byte lane per center
   assign row_addr = RW'(head.row);
   assign lane     = CW'(head.cidx);
   assign tbl_wr   = pop && (head.op == lnca_pkg::OP_LOAD) && head.in_range;
   assign tbl_rd   = pop && (head.op == lnca_pkg::OP_POINT);

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         tbl_mem[row_addr][lane*lnca_pkg::VAL_W +: lnca_pkg::VAL_W] <= head.value;
      end
      if (tbl_rd) begin
         rd_data_ff <= tbl_mem[row_addr];
      end
   end

   // Accumulate stage runs in the cycle after the table read
   assign acc_vld_in = tbl_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= 1'b0;
      end else begin
         acc_vld_ff <= acc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_rd) begin
         acc_value_ff <= head.value;
      end
   end

   // One saturating L1 accumulator per center
   for (genvar c = 0; c < MAX_CENTERS; c++) begin : g_lane
      logic [lnca_pkg::VAL_W-1:0]  t;
      logic [lnca_pkg::VAL_W-1:0]  diff;
      logic [lnca_pkg::DIST_W:0]   sum;

      assign t    = rd_data_ff[c*lnca_pkg::VAL_W +: lnca_pkg::VAL_W];
      assign diff = (acc_value_ff >= t) ? acc_value_ff - t : t - acc_value_ff;
      assign sum  = {1'b0, dist_ff[c]} + (lnca_pkg::DIST_W+1)'(diff);

      always_comb begin
         dist_in[c] = dist_ff[c];
         if (emit_fire) begin
            dist_in[c] = '0;
         end else if (acc_vld_ff && (32'(c) < 32'(ncent_eff))) begin
            dist_in[c] = (sum > {1'b0, lnca_pkg::DIST_MAX}) ? lnca_pkg::DIST_MAX
                                                          : sum[lnca_pkg::DIST_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dist_ff[c] <= '0;
         end else begin
            dist_ff[c] <= dist_in[c];
         end
      end
   end

   // Nearest center scan, one center per cycle, lowest index wins ties
   assign dist_sel = dist_ff[CW'(scan_idx_ff)];

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      best_in     = best_ff;
      best_d_in   = best_d_ff;
      case (state_ff)
         S_RUN: begin
            if (tbl_rd && head.last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in    = S_SCAN;
            scan_idx_in = '0;
            best_in     = '0;
            best_d_in   = lnca_pkg::DIST_MAX;
         end
         S_SCAN: begin
            if (scan_idx_ff < ncent_eff) begin
               if (dist_sel < best_d_ff) begin
                  best_in   = scan_idx_ff;
                  best_d_in = dist_sel;
               end
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_RUN;
         scan_idx_ff <= '0;
         best_ff     <= '0;
         best_d_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         best_ff     <= best_in;
         best_d_ff   <= best_d_in;
      end
   end

   // Member counts: one read port shared by readback and update
   assign cnt_idx = (state_ff == S_EMIT) ? CW'(best_ff) : CW'(head.cidx);
   assign cnt_rd  = cnt_ff[cnt_idx];
   assign cnt_new = (cnt_rd == lnca_pkg::CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || clear_fire) begin
         for (int c = 0; c < MAX_CENTERS; c++) begin
            cnt_ff[c] <= '0;
         end
      end else if (emit_fire) begin
         cnt_ff[cnt_idx] <= cnt_new;
      end
   end

   // Result register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire || read_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_res_ff.kind     <= lnca_pkg::KIND_ASSIGN;
         rsp_res_ff.center   <= best_ff[lnca_pkg::CIDX_W-1:0];
         rsp_res_ff.distance <= best_d_ff;
         rsp_res_ff.count    <= cnt_new;
      end else if (read_fire) begin
         rsp_res_ff.kind     <= lnca_pkg::KIND_READBACK;
         rsp_res_ff.center   <= head.cidx;
         rsp_res_ff.distance <= '0;
         rsp_res_ff.count    <= head.in_range ? cnt_rd : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;

endmodule

// File: hdl/l1_nearest_center_assign_top.sv
// A beat enters the queue on acceptance; a readback result is registered when the read pops.
// Throughput: one beat per cycle while the queue has room; the last point coordinate holds the
// back end in its accumulate, scan and emit states while the scan runs one center per cycle.
// Reset: synchronous, active high; clears counts, distances, position, queue and config
// registers to 64 dims / 16 centers. The center table is undefined until loaded.
// Top level of the L1 nearest-center block; uses lnca_pkg, lnca_front, lnca_fifo, lnca_back.
module l1_nearest_center_assign_top #(
   parameter int MAX_DIMS    = 64,
   parameter int MAX_CENTERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // center_index[3:0], dim_index[9:4], value[17:10]
   input  logic [1:0]   req_tuser,   // opcode[1:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // chosen_center[3:0], best_distance[17:4],
                                     // member_count[33:18]
   output logic [0:0]   rsp_tuser,   // result_kind[0]
   // configuration
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   logic [lnca_pkg::DIMS_W-1:0]  dims_ff;
   logic [lnca_pkg::CENT_W-1:0]  cent_ff;
   logic [lnca_pkg::DIMS_W-1:0]  dims_eff;
   logic [lnca_pkg::CENT_W-1:0]  ncent_eff;

   logic                         q_push, q_full, q_pop, q_empty;
   lnca_pkg::lnca_item_type      q_item, q_head;
   lnca_pkg::lnca_result_type    res;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= lnca_pkg::DIMS_RESET;
         cent_ff <= lnca_pkg::CENT_RESET;
      end else if (csr_we) begin
         if (csr_index == lnca_pkg::CSR_DIMS) begin
            dims_ff <= csr_wdata;
         end else if (csr_index == lnca_pkg::CSR_CENTERS) begin
            cent_ff <= csr_wdata[lnca_pkg::CENT_W-1:0];
         end
      end
   end

   // Clamp register values into 1..maximum
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = 7'd1;
      end else if (32'(dims_ff) > MAX_DIMS) begin
         dims_eff = lnca_pkg::DIMS_W'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
      if (cent_ff == '0) begin
         ncent_eff = 5'd1;
      end else if (32'(cent_ff) > MAX_CENTERS) begin
         ncent_eff = lnca_pkg::CENT_W'(MAX_CENTERS);
      end else begin
         ncent_eff = cent_ff;
      end
   end

   lnca_front #(
      .MAX_DIMS    (MAX_DIMS),
      .MAX_CENTERS (MAX_CENTERS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_op    (lnca_pkg::lnca_op_type'(req_tuser)),
      .in_cidx  (req_tdata[3:0]),
      .in_didx  (req_tdata[9:4]),
      .in_value (req_tdata[17:10]),
      .dims_eff (dims_eff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_item)
   );

   lnca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   lnca_back #(
      .MAX_DIMS    (MAX_DIMS),
      .MAX_CENTERS (MAX_CENTERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .ncent_eff (ncent_eff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res)
   );

   // Pack the result beat
   assign rsp_tdata = {6'b0, res.count, res.distance, res.center};
   assign rsp_tuser = res.kind;

endmodule

// File: hdl/lnca_checker.sv
// Port-level checks for the L1 nearest-center block, bound to its top level.
// Depends on l1_nearest_center_assign_top and lnca_pkg.
module lnca_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser
);

   // No result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Readback carries zero distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lnca_pkg::KIND_READBACK |-> rsp_tdata[17:4] == '0)
      else $error("readback with nonzero distance");

   // An assignment always reports the incremented, nonzero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lnca_pkg::KIND_ASSIGN |-> rsp_tdata[33:18] != '0)
      else $error("assignment with zero member count");

   // Pad bits stay clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == '0)
      else $error("result pad bits set");

endmodule

bind l1_nearest_center_assign_top lnca_checker u_lnca_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/nearest_center_check.sv
`timescale 1ns / 100ps
// Bus monitor and predictor for the L1 nearest-center block: tracks register writes,
// keeps its own copy of the center table, distances and counts, and checks result beats.
// Depends on lnca_pkg for opcodes, register indexes and result kinds.
module nearest_center_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   output int unsigned mismatch_cnt,
   output int unsigned results_owed
);

   localparam int SHADOW_CENTERS = 16;
   localparam int SHADOW_DIMS    = 64;

   typedef struct packed {
      logic        kind;
      logic [3:0]  center;
      logic [13:0] distance;
      logic [15:0] count;
   } nc_result_type;

   // Shadow state of the block
   logic [7:0]  center_mem [SHADOW_CENTERS][SHADOW_DIMS];
   int unsigned run_dist [SHADOW_CENTERS];
   int unsigned member_cnt [SHADOW_CENTERS];
   int unsigned coord_pos;
   logic [6:0]  dims_reg;
   logic [4:0]  cent_reg;
   int unsigned bad_beats;

   // Assignments and readbacks still owed by the block, oldest first
   nc_result_type nearest_center_q [$];

   // Apply one request beat to the shadow state and queue any result it causes
   task automatic accumulate_l1_beat(input lnca_pkg::lnca_op_type op, input logic [3:0] cidx,
                                     input logic [5:0] didx, input logic [7:0] val);
      int unsigned dims, ncent, diff, best, best_d, t, s;
      nc_result_type r;
      dims  = (dims_reg == 0) ? 1 : ((dims_reg > SHADOW_DIMS) ? SHADOW_DIMS : dims_reg);
      ncent = (cent_reg == 0) ? 1 :
              ((cent_reg > SHADOW_CENTERS) ? SHADOW_CENTERS : cent_reg);
      case (op)
         lnca_pkg::OP_LOAD: center_mem[cidx][didx] = val;
         lnca_pkg::OP_CLEAR: begin
            foreach (member_cnt[c]) member_cnt[c] = 0;
         end
         lnca_pkg::OP_READ: begin
            r.kind     = lnca_pkg::KIND_READBACK;
            r.center   = cidx;
            r.distance = '0;
            r.count    = member_cnt[cidx][15:0];
            nearest_center_q.push_back(r);
         end
         default: begin
            // accumulate |value - center| for every center in use
            for (int c = 0; c < ncent; c++) begin
               t    = center_mem[c][coord_pos];
               diff = (val >= t) ? val - t : t - val;
               s    = run_dist[c] + diff;
               run_dist[c] = (s > lnca_pkg::DIST_MAX) ? lnca_pkg::DIST_MAX : s;
            end
            if (coord_pos + 1 < dims) begin
               coord_pos++;
            end else begin
               // pick the nearest, lowest index on ties
               best   = 0;
               best_d = run_dist[0];
               for (int c = 1; c < ncent; c++) begin
                  if (run_dist[c] < best_d) begin
                     best_d = run_dist[c];
                     best   = c;
                  end
               end
               if (member_cnt[best] < lnca_pkg::CNT_MAX) member_cnt[best]++;
               r.kind     = lnca_pkg::KIND_ASSIGN;
               r.center   = best[3:0];
               r.distance = best_d[13:0];
               r.count    = member_cnt[best][15:0];
               nearest_center_q.push_back(r);
               foreach (run_dist[c]) run_dist[c] = 0;
               coord_pos = 0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      nc_result_type got, want;
      if (reset) begin
         foreach (run_dist[c]) run_dist[c] = 0;
         foreach (member_cnt[c]) member_cnt[c] = 0;
         coord_pos = 0;
         dims_reg  = lnca_pkg::DIMS_RESET;
         cent_reg  = lnca_pkg::CENT_RESET;
         bad_beats = 0;
         nearest_center_q.delete();
      end else begin
         // compare each result beat against the oldest owed result
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = rsp_tuser[0];
            got.center   = rsp_tdata[3:0];
            got.distance = rsp_tdata[17:4];
            got.count    = rsp_tdata[33:18];
            if (nearest_center_q.size() == 0) begin
               bad_beats++;
               if (bad_beats <= 10) begin
                  $display("unexpected result beat: kind %0d center %0d distance %0d count %0d",
                           got.kind, got.center, got.distance, got.count);
               end
            end else begin
               want = nearest_center_q.pop_front();
               if (got.kind != want.kind || got.center != want.center ||
                   got.distance != want.distance || got.count != want.count) begin
                  bad_beats++;
                  if (bad_beats <= 10) begin
                     $display("result mismatch: expected kind %0d center %0d distance %0d %s",
                              want.kind, want.center, want.distance,
                              $sformatf("count %0d, got kind %0d center %0d distance %0d count %0d",
                                        want.count, got.kind, got.center, got.distance,
                                        got.count));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accumulate_l1_beat(lnca_pkg::lnca_op_type'(req_tuser), req_tdata[3:0],
                               req_tdata[9:4], req_tdata[17:10]);
         end
         if (csr_we) begin
            if (csr_index == lnca_pkg::CSR_DIMS) dims_reg = csr_wdata;
            else cent_reg = csr_wdata[4:0];
         end
      end
      mismatch_cnt <= bad_beats;
      results_owed <= nearest_center_q.size();
   end

endmodule

// File: dv/l1_nearest_center_assign_top_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the L1 nearest-center block: loads the center table, streams
// points under several register settings, and relies on nearest_center_check for checking.
module l1_nearest_center_assign_top_test;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int LONG_STALL     = 300;
   localparam int PHASE_BEATS    = 90;
   localparam int NUM_PHASES     = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // center_index[3:0], dim_index[9:4], value[17:10]
   logic [1:0]  req_tuser  = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // chosen_center[3:0], best_distance[17:4], member_count[33:18]
   logic [0:0]  rsp_tuser;         // result_kind[0]
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [6:0]  csr_wdata  = '0;

   int unsigned mismatch_cnt;
   int unsigned results_owed;
   int unsigned stall_asked   = 0;
   int unsigned stall_handled = 0;
   int unsigned stall_left    = 0;
   logic        no_idle       = 1'b0;
   int unsigned idle_cycles   = 0;

   // table entries written so far, and the widest dims setting used
   bit          loaded [16][64];
   int unsigned span_dims = 1;

   // register settings per phase, extremes and out-of-range values included
   int unsigned cfg_dims [NUM_PHASES] = '{3, 0, 1, 127, 8, 2, 64, 6};
   int unsigned cfg_cent [NUM_PHASES] = '{4, 0, 16, 2, 31, 5, 16, 16};

   always #5 clock = ~clock;

   l1_nearest_center_assign_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   nearest_center_check i_nearest_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatch_cnt (mismatch_cnt),
      .results_owed (results_owed)
   );

   // Result side: random backpressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_handled != stall_asked) begin
         stall_handled <= stall_handled + 1;
         stall_left    <= LONG_STALL;
         rsp_tready    <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 19);
      end
   end

   // Abort when no beat moves on either channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request beat, with an occasional gap, and hold it until taken
   task automatic send_beat(input lnca_pkg::lnca_op_type op, input logic [3:0] cidx,
                            input logic [5:0] didx, input logic [7:0] val);
      if (!no_idle && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, val, didx, cidx};
      if (op == lnca_pkg::OP_LOAD) loaded[cidx][didx] = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Write a register once the block has drained
   task automatic write_csr(input logic [0:0] idx, input logic [6:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Apply a setting, then fill every table entry a point may read under it
   task automatic set_config(input int unsigned dims, input int unsigned cents);
      int unsigned d_eff, k_eff;
      write_csr(lnca_pkg::CSR_DIMS, dims[6:0]);
      write_csr(lnca_pkg::CSR_CENTERS, cents[6:0]);
      d_eff = (dims == 0) ? 1 : ((dims > 64) ? 64 : dims);
      k_eff = (cents == 0) ? 1 : ((cents > 16) ? 16 : cents);
      if (d_eff > span_dims) span_dims = d_eff;
      for (int c = 0; c < k_eff; c++) begin
         for (int p = 0; p < span_dims; p++) begin
            if (!loaded[c][p]) begin
               send_beat(lnca_pkg::OP_LOAD, 4'(c), 6'(p), 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Mostly point coordinates, with loads, readbacks and clears mixed in
   task automatic random_beat();
      int unsigned pick;
      logic [7:0]  v;
      logic [3:0]  ci;
      logic [5:0]  di;
      pick = $urandom_range(0, 99);
      ci   = 4'($urandom_range(0, 15));
      di   = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else v = 8'($urandom_range(0, 255));
      if (pick < 70) send_beat(lnca_pkg::OP_POINT, ci, di, v);
      else if (pick < 82) send_beat(lnca_pkg::OP_LOAD, ci, di, v);
      else if (pick < 94) send_beat(lnca_pkg::OP_READ, ci, di, v);
      else send_beat(lnca_pkg::OP_CLEAR, ci, di, v);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_config(3, 4);

      // centers 0 and 1 identical so their distances tie
      send_beat(lnca_pkg::OP_LOAD, 4'd0, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_LOAD, 4'd0, 6'd1, 8'hFF);
      send_beat(lnca_pkg::OP_LOAD, 4'd0, 6'd2, 8'h80);
      send_beat(lnca_pkg::OP_LOAD, 4'd1, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_LOAD, 4'd1, 6'd1, 8'hFF);
      send_beat(lnca_pkg::OP_LOAD, 4'd1, 6'd2, 8'h80);
      // highest indexes, outside the compared region
      send_beat(lnca_pkg::OP_LOAD, 4'd15, 6'd63, 8'hFF);
      send_beat(lnca_pkg::OP_LOAD, 4'd15, 6'd63, 8'h00);
      // point on top of both tied centers; index fields are ignored
      send_beat(lnca_pkg::OP_POINT, 4'd15, 6'd63, 8'h00);
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'hFF);
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'h80);
      // point at the opposite corner
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'hFF);
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_POINT, 4'd15, 6'd63, 8'hFF);
      // counts read back, cleared, read again
      send_beat(lnca_pkg::OP_READ, 4'd0, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_READ, 4'd1, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_READ, 4'd15, 6'd63, 8'hFF);
      send_beat(lnca_pkg::OP_CLEAR, 4'd0, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_READ, 4'd0, 6'd0, 8'h00);
      // table write and readback in the middle of a point
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'h10);
      send_beat(lnca_pkg::OP_LOAD, 4'd2, 6'd1, 8'h55);
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'h20);
      send_beat(lnca_pkg::OP_READ, 4'd2, 6'd0, 8'h00);
      send_beat(lnca_pkg::OP_POINT, 4'd0, 6'd0, 8'h30);

      // random phases; a point left open at a boundary runs under the new dims
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_config(cfg_dims[ph], cfg_cent[ph]);
         if (ph == 2) stall_asked <= stall_asked + 1;
         no_idle <= (ph == 5);
         repeat (PHASE_BEATS) random_beat();
      end

      // drain and report
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && results_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
